// File: hw/rtl/permenum_pkg.sv
// Shared types, constants and helpers for the permutation enumerator.
`default_nettype none

package permenum_pkg;

    localparam int MAX_LEN     = 8;
    localparam int STORE_DEPTH = 8;
    localparam int VAL_W       = 3;
    localparam int CNT_W       = 4;
    localparam int LEN_W       = 4;
    localparam int LVL_W       = $clog2(MAX_LEN + 1);

    typedef logic [VAL_W-1:0] val_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [LEN_W-1:0] len_t;
    typedef logic [LVL_W-1:0] lvl_t;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    typedef struct packed {
        logic rd_en;
        val_t rd_a;
        val_t rd_b;
        logic map_we;
        val_t map_waddr;
        val_t map_wdata;
        logic inv_we;
        val_t inv_waddr;
        val_t inv_wdata;
    } store_cmd_t;

    typedef struct packed {
        val_t map_a;
        val_t map_b;
        val_t inv_a;
    } store_rsp_t;

    typedef struct packed {
        logic valid;
        val_t position;
        val_t value;
        val_t inverse;
        logic fresh;
        logic last;
    } emit_t;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_CHK    = 10'b0000000010,
        S_CHKEND = 10'b0000000100,
        S_ADV    = 10'b0000001000,
        S_ADVUPD = 10'b0000010000,
        S_SWRD   = 10'b0000100000,
        S_SWW1   = 10'b0001000000,
        S_SWW2   = 10'b0010000000,
        S_EMRD   = 10'b0100000000,
        S_EMIT   = 10'b1000000000
    } state_t;

    typedef enum logic [1:0] {
        RET_CHK    = 2'd0,
        RET_ADV2   = 2'd1,
        RET_ADVNXT = 2'd2
    } ret_t;

    function automatic lvl_t clamp_len(input len_t len);
        lvl_t res;
        if (len == '0)
            res = LVL_W'(1);
        else if (32'(len) > MAX_LEN)
            res = LVL_W'(MAX_LEN);
        else
            res = LVL_W'(len);
        return res;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/permenum_store.sv
// Map and inverse memories: one write port each, registered reads.
`default_nettype none

module permenum_store (
    input  logic                     clk,
    input  permenum_pkg::store_cmd_t cmd,
    output permenum_pkg::store_rsp_t rsp
);
    import permenum_pkg::*;

    val_t map_mem [STORE_DEPTH];
    val_t inv_mem [STORE_DEPTH];
    val_t map_a_reg;
    val_t map_b_reg;
    val_t inv_a_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.map_we)
        begin
            map_mem[cmd.map_waddr] <= cmd.map_wdata;
        end
        if (cmd.inv_we)
        begin
            inv_mem[cmd.inv_waddr] <= cmd.inv_wdata;
        end
        if (cmd.rd_en)
        begin
            map_a_reg <= map_mem[cmd.rd_a];
            map_b_reg <= map_mem[cmd.rd_b];
            inv_a_reg <= inv_mem[cmd.rd_a];
        end
    end

    assign rsp.map_a = map_a_reg;
    assign rsp.map_b = map_b_reg;
    assign rsp.inv_a = inv_a_reg;

endmodule

`default_nettype wire

// File: hw/rtl/permenum_seq.sv
// Sequencer: level walk, shared swap unit and result readout.
`default_nettype none

module permenum_seq (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     func,
    input  permenum_pkg::val_t       position,
    input  permenum_pkg::val_t       entry_value,
    input  permenum_pkg::lvl_t       len,
    input  logic                     out_free,
    output logic                     idle,
    output permenum_pkg::emit_t      emit,
    output permenum_pkg::store_cmd_t cmd,
    input  permenum_pkg::store_rsp_t rsp
);
    import permenum_pkg::*;

    state_t state_reg, state_next;
    ret_t   ret_reg, ret_next;
    lvl_t   lvl_reg, lvl_next;
    lvl_t   tgt_reg, tgt_next;
    lvl_t   adv_reg, adv_next;
    lvl_t   len_reg, len_next;
    logic   top_reg, top_next;
    logic   res_reg, res_next;
    logic   fresh_reg, fresh_next;
    val_t   emit_idx_reg, emit_idx_next;
    cnt_t   ins_reg [MAX_LEN+1];
    cnt_t   ins_next [MAX_LEN+1];
    logic   done_reg [MAX_LEN+1];
    logic   done_next [MAX_LEN+1];
    cnt_t   swap_a_reg, swap_a_next;
    cnt_t   swap_b_reg, swap_b_next;
    cnt_t   hold_reg, hold_next;

    always_comb
    begin
        cnt_t ins_cur;
        logic chk_res;
        logic chk_end;
        logic rtn;

        ins_cur       = '0;
        chk_res       = res_reg;
        chk_end       = 1'b0;
        rtn           = 1'b0;
        state_next    = state_reg;
        ret_next      = ret_reg;
        lvl_next      = lvl_reg;
        tgt_next      = tgt_reg;
        adv_next      = adv_reg;
        len_next      = len_reg;
        top_next      = top_reg;
        res_next      = res_reg;
        fresh_next    = fresh_reg;
        emit_idx_next = emit_idx_reg;
        swap_a_next   = swap_a_reg;
        swap_b_next   = swap_b_reg;
        hold_next     = hold_reg;
        ins_next      = ins_reg;
        done_next     = done_reg;
        cmd           = '0;
        emit          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (func == FUNC_LOAD)
                    begin
                        cmd.map_we    = 1'b1;
                        cmd.map_waddr = position;
                        cmd.map_wdata = entry_value;
                        cmd.inv_we    = 1'b1;
                        cmd.inv_waddr = entry_value;
                        cmd.inv_wdata = position;
                        for (int j = 0; j <= MAX_LEN; j++)
                        begin
                            ins_next[j]  = '0;
                            done_next[j] = 1'b0;
                        end
                    end
                    else
                    begin
                        len_next   = len;
                        lvl_next   = '0;
                        tgt_next   = len;
                        top_next   = 1'b1;
                        state_next = S_CHK;
                    end
                end
            end
            S_CHK:
            begin
                if (lvl_reg == '0)
                begin
                    chk_res = !done_reg[0];
                end
                else
                begin
                    ins_cur = ins_reg[lvl_reg];
                    chk_res = res_reg || (ins_cur != CNT_W'(lvl_reg - 1'b1));
                end
                res_next = chk_res;
                if (lvl_reg != '0 && !chk_res && !done_reg[lvl_reg] && ins_cur != '0)
                begin
                    // restoring swap of this level
                    done_next[lvl_reg] = 1'b1;
                    swap_a_next        = ins_cur;
                    swap_b_next        = ins_cur - 1'b1;
                    ret_next           = RET_CHK;
                    state_next         = S_SWRD;
                end
                else
                begin
                    chk_end = 1'b1;
                end
            end
            S_CHKEND:
            begin
                chk_end = 1'b1;
            end
            S_ADV:
            begin
                if (adv_reg == '0)
                begin
                    done_next[0]  = 1'b1;
                    emit_idx_next = '0;
                    state_next    = S_EMRD;
                end
                else
                begin
                    lvl_next   = '0;
                    tgt_next   = adv_reg - 1'b1;
                    top_next   = 1'b0;
                    state_next = S_CHK;
                end
            end
            S_ADVUPD:
            begin
                ins_cur           = ins_reg[adv_reg];
                hold_next         = ins_cur;
                ins_next[adv_reg] = ins_cur + 1'b1;
                for (int j = 0; j <= MAX_LEN; j++)
                begin
                    if (LVL_W'(j) < adv_reg)
                    begin
                        ins_next[j]  = '0;
                        done_next[j] = 1'b0;
                    end
                end
                swap_a_next = CNT_W'(adv_reg - 1'b1);
                if (ins_cur != '0)
                begin
                    swap_b_next = ins_cur - 1'b1;
                    ret_next    = RET_ADV2;
                end
                else
                begin
                    swap_b_next = ins_cur;
                    ret_next    = RET_ADVNXT;
                end
                state_next = S_SWRD;
            end
            S_SWRD:
            begin
                if (swap_a_reg >= CNT_W'(STORE_DEPTH) || swap_b_reg >= CNT_W'(STORE_DEPTH))
                begin
                    rtn = 1'b1;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_a   = swap_a_reg[VAL_W-1:0];
                    cmd.rd_b   = swap_b_reg[VAL_W-1:0];
                    state_next = S_SWW1;
                end
            end
            S_SWW1:
            begin
                cmd.map_we    = 1'b1;
                cmd.map_waddr = swap_b_reg[VAL_W-1:0];
                cmd.map_wdata = rsp.map_a;
                cmd.inv_we    = 1'b1;
                cmd.inv_waddr = rsp.map_a;
                cmd.inv_wdata = swap_b_reg[VAL_W-1:0];
                state_next    = S_SWW2;
            end
            S_SWW2:
            begin
                cmd.map_we    = 1'b1;
                cmd.map_waddr = swap_a_reg[VAL_W-1:0];
                cmd.map_wdata = rsp.map_b;
                cmd.inv_we    = 1'b1;
                cmd.inv_waddr = rsp.map_b;
                cmd.inv_wdata = swap_a_reg[VAL_W-1:0];
                rtn           = 1'b1;
            end
            S_EMRD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_a   = emit_idx_reg;
                cmd.rd_b   = emit_idx_reg;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    emit.valid    = 1'b1;
                    emit.position = emit_idx_reg;
                    emit.value    = rsp.map_a;
                    emit.inverse  = rsp.inv_a;
                    emit.fresh    = fresh_reg;
                    emit.last     = (LVL_W'(emit_idx_reg) + LVL_W'(1)) == len_reg;
                    if (emit.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + 1'b1;
                        state_next    = S_EMRD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (chk_end)
        begin
            if (lvl_reg == tgt_reg)
            begin
                if (top_reg)
                begin
                    fresh_next = chk_res;
                    if (chk_res)
                    begin
                        adv_next   = len_reg;
                        state_next = S_ADV;
                    end
                    else
                    begin
                        emit_idx_next = '0;
                        state_next    = S_EMRD;
                    end
                end
                else if (chk_res)
                begin
                    adv_next   = adv_reg - 1'b1;
                    state_next = S_ADV;
                end
                else
                begin
                    state_next = S_ADVUPD;
                end
            end
            else
            begin
                lvl_next   = lvl_reg + 1'b1;
                state_next = S_CHK;
            end
        end

        if (rtn)
        begin
            unique case (ret_reg)
                RET_CHK:
                begin
                    state_next = S_CHKEND;
                end
                RET_ADV2:
                begin
                    // second swap of the insertion move
                    swap_b_next = hold_reg;
                    ret_next    = RET_ADVNXT;
                    state_next  = S_SWRD;
                end
                RET_ADVNXT:
                begin
                    adv_next   = adv_reg - 1'b1;
                    state_next = S_ADV;
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ret_reg      <= RET_CHK;
            lvl_reg      <= '0;
            tgt_reg      <= '0;
            adv_reg      <= '0;
            len_reg      <= '0;
            top_reg      <= 1'b0;
            res_reg      <= 1'b0;
            fresh_reg    <= 1'b0;
            emit_idx_reg <= '0;
            for (int j = 0; j <= MAX_LEN; j++)
            begin
                ins_reg[j]  <= '0;
                done_reg[j] <= 1'b0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            lvl_reg      <= lvl_next;
            tgt_reg      <= tgt_next;
            adv_reg      <= adv_next;
            len_reg      <= len_next;
            top_reg      <= top_next;
            res_reg      <= res_next;
            fresh_reg    <= fresh_next;
            emit_idx_reg <= emit_idx_next;
            ins_reg      <= ins_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        swap_a_reg <= swap_a_next;
        swap_b_reg <= swap_b_next;
        hold_reg   <= hold_next;
    end

    assign idle = (state_reg == S_IDLE);

endmodule

`default_nettype wire

// File: hw/rtl/permutation_enumerator_top.sv
// Top level of the permutation enumerator.
//
//  channel | signals                                         | dir
//  --------+-------------------------------------------------+-----
//  in      | in_valid, in_ready, func, position, entry_value | in
//  out     | out_valid, out_ready, out_position, out_value,  | out
//          | out_inverse, fresh_permutation, last            |
//  cfg     | cfg_wr_en, cfg_wr_data (length_in_use)          | in
//
// A load is written straight into the memories. An advancing step is accepted,
// checks the levels, walks the advance, then reads and emits each result beat;
// a step that finds the enumeration done skips the walk. Each swap passes through
// a read state and two write states; each restoring swap or insertion update one more.
// Reset clears levels and control; map and inverse memories are not reset.
// A stalled out beat holds; the sequencer waits for the output register.
`default_nettype none

module permutation_enumerator_top (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       in_valid,
    output logic                      in_ready,
    input  wire                       func,
    input  wire  [2:0]                position,
    input  wire  [2:0]                entry_value,
    input  wire                       cfg_wr_en,
    input  wire  [3:0]                cfg_wr_data,
    output logic                      out_valid,
    input  wire                       out_ready,
    output logic [2:0]                out_position,
    output logic [2:0]                out_value,
    output logic [2:0]                out_inverse,
    output logic                      fresh_permutation,
    output logic                      last
);
    import permenum_pkg::*;

    len_t       length_in_use_reg;
    logic       out_valid_reg;
    val_t       out_position_reg;
    val_t       out_value_reg;
    val_t       out_inverse_reg;
    logic       fresh_reg;
    logic       last_reg;
    logic       seq_idle;
    logic       start;
    logic       out_free;
    emit_t      emit;
    store_cmd_t cmd;
    store_rsp_t rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_in_use_reg <= LEN_W'(8);
        end
        else if (cfg_wr_en)
        begin
            length_in_use_reg <= cfg_wr_data;
        end
    end

    assign in_ready = seq_idle;
    assign start    = in_valid && seq_idle;
    assign out_free = !out_valid_reg || out_ready;

    permenum_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .func        (func),
        .position    (position),
        .entry_value (entry_value),
        .len         (clamp_len(length_in_use_reg)),
        .out_free    (out_free),
        .idle        (seq_idle),
        .emit        (emit),
        .cmd         (cmd),
        .rsp         (rsp)
    );

    permenum_store u_store (
        .clk (clk),
        .cmd (cmd),
        .rsp (rsp)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            out_position_reg <= emit.position;
            out_value_reg    <= emit.value;
            out_inverse_reg  <= emit.inverse;
            fresh_reg        <= emit.fresh;
            last_reg         <= emit.last;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_position      = out_position_reg;
    assign out_value         = out_value_reg;
    assign out_inverse       = out_inverse_reg;
    assign fresh_permutation = fresh_reg;
    assign last              = last_reg;

endmodule

`default_nettype wire

// File: hw/rtl/permenum_chk.sv
// Port-level checker for the permutation enumerator, bound to the top level.
`default_nettype none

module permenum_chk (
    input wire       clk,
    input wire       rst_n,
    input wire       in_valid,
    input wire       in_ready,
    input wire       func,
    input wire       out_valid,
    input wire       out_ready,
    input wire [2:0] out_value,
    input wire       last
);
    import permenum_pkg::*;

    // a step beat makes the block busy
    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && func == FUNC_STEP) |=> !in_ready)
        else $error("input ready after step beat");

    // a load beat leaves the block ready
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && func == FUNC_LOAD) |=> in_ready)
        else $error("input not ready after load beat");

    // run still in progress while a non-final beat is shown
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> !in_ready)
        else $error("input ready in the middle of a result run");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_value) && $stable(last)))
        else $error("stalled out beat changed");

endmodule

bind permutation_enumerator_top permenum_chk u_permenum_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value),
    .last      (last)
);

`default_nettype wire
